[hdl/mandelbrot_escape_count_assert.svh]
// Assertion macros for the Mandelbrot escape counter checker.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef MANDELBROT_ESCAPE_COUNT_ASSERT_SVH
`define MANDELBROT_ESCAPE_COUNT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MEC_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MEC_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mec_pkg.sv]
// Shared constants and types for the Mandelbrot escape counter.
// No dependencies; used by the interfaces, the top level and the checker.
package mec_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 26;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int POINT_W    = 31;
    localparam int RADIUS_W   = 31;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_MAX_ITER = cfg_idx_t'(0);
    localparam cfg_idx_t REG_RADIUS   = cfg_idx_t'(1);

    localparam int MAX_ITER_RESET = 256;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(268435456);

endpackage

[hdl/mec_if.sv]
// Valid/ready channel interfaces for points, results and register writes.
// Depends on mec_pkg for field widths.
interface mec_point_if
    import mec_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic signed [POINT_W-1:0] cx;
    logic signed [POINT_W-1:0] cy;

    modport source (output valid, output cx, output cy, input ready);
    modport sink   (input valid, input cx, input cy, output ready);
endinterface

interface mec_result_if
    import mec_pkg::*;
    #(parameter int COUNT_WIDTH = COUNT_WIDTH_DEF)
    ();
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] iter_count;
    logic                   escaped;

    modport source (output valid, output iter_count, output escaped, input ready);
    modport sink   (input valid, input iter_count, input escaped, output ready);
endinterface

interface mec_cfg_if
    import mec_pkg::*;
    ();
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/mandelbrot_escape_count.sv]
// Mandelbrot escape-time counter: one shared multiplier under a small sequencer.
// Depends on mec_pkg and the channel interfaces in mec_if.sv.
//
// Usage: a point request (cx, cy, signed fixed point with FRAC_BITS fraction
// bits) is taken on the point channel while the sequencer is idle. The block
// iterates z = z*z + c starting from z = c and returns one result request on
// the result channel: iter_count, the number of passing magnitude tests, and
// escaped, set when a test failed before max_iterations passes.
// In each iteration the one multiplier forms x*x, y*y and x*y in turn, and a
// final step does the threshold compare and the update. The sequencer takes one
// point at a time; point.ready is high only when idle.
// A finished result sits in an output register; the next point is accepted
// while that result waits, and if the receiver stalls the sequencer holds its
// new result until the register frees up.
// The configuration channel is always ready: index 0 writes max_iterations,
// index 1 writes escape_radius_sq, other indexes are ignored. Writes are meant
// for idle periods only. Reset (rst_n low, asynchronous) returns the sequencer
// to idle, clears the result register and restores the register defaults
// (256 iterations, threshold 4.0).
module mandelbrot_escape_count
    import mec_pkg::*;
    #(
        parameter int COORD_WIDTH = COORD_WIDTH_DEF,
        parameter int FRAC_BITS   = FRAC_BITS_DEF,
        parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
    )
    (
        input  logic              clk,
        input  logic              rst_n,
        mec_point_if.sink         point,
        mec_result_if.source      result,
        mec_cfg_if.sink           cfg
    );

    localparam int PROD_W = 2 * COORD_WIDTH;
    // The accumulator must hold the sum of two squares and the shifted threshold.
    localparam int ACC_W  = (PROD_W + 1 > RADIUS_W + FRAC_BITS) ? PROD_W + 1
                                                               : RADIUS_W + FRAC_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_XX   = 3'd1;
    localparam logic [2:0] ST_YY   = 3'd2;
    localparam logic [2:0] ST_XY   = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // Configuration registers.
    logic [COUNT_WIDTH-1:0] max_iter_reg;
    logic [RADIUS_W-1:0]    radius_reg;

    // Sequencer state and iteration variables.
    logic [2:0]                    state_reg, state_next;
    logic signed [COORD_WIDTH-1:0] x_reg, x_next;
    logic signed [COORD_WIDTH-1:0] y_reg, y_next;
    logic signed [COORD_WIDTH-1:0] cx_reg, cx_next;
    logic signed [COORD_WIDTH-1:0] cy_reg, cy_next;
    logic [COUNT_WIDTH-1:0]        n_reg, n_next;
    logic                          esc_reg, esc_next;

    // Shared multiplier and its product registers.
    logic signed [COORD_WIDTH-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      xx_reg, xx_next;
    logic signed [PROD_W-1:0]      yy_reg, yy_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0] out_count_reg, out_count_next;
    logic                   out_esc_reg, out_esc_next;

    // Compare and update datapath.
    logic [ACC_W-1:0]              mag_sum;
    logic [ACC_W-1:0]              thr;
    logic                          over_thr;
    logic signed [ACC_W-1:0]       diff;
    logic signed [ACC_W-1:0]       diff_sh;
    logic signed [PROD_W-1:0]      xy_sh;
    logic [COUNT_WIDTH-1:0]        n_inc;
    logic                          point_acc;
    logic                          out_free;

    assign point.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;
    assign point_acc   = point.valid && (state_reg == ST_IDLE);

    assign result.valid      = out_valid_reg;
    assign result.iter_count = out_count_reg;
    assign result.escaped    = out_esc_reg;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || result.ready;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            ST_XX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            ST_YY:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Squares are exact and non-negative, so the magnitude compare is unsigned.
    assign mag_sum  = ACC_W'(xx_reg) + ACC_W'(yy_reg);
    assign thr      = ACC_W'({radius_reg, {FRAC_BITS{1'b0}}});
    assign over_thr = mag_sum > thr;
    assign diff     = ACC_W'(xx_reg) - ACC_W'(yy_reg);
    assign diff_sh  = diff >>> FRAC_BITS;
    // Doubling x*y folds into a shift that is one bit shorter.
    assign xy_sh    = prod_reg >>> (FRAC_BITS - 1);
    assign n_inc    = n_reg + COUNT_WIDTH'(1);

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        n_next         = n_reg;
        esc_next       = esc_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_count_next = out_count_reg;
        out_esc_next   = out_esc_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (point_acc)
                begin
                    cx_next  = COORD_WIDTH'(point.cx);
                    cy_next  = COORD_WIDTH'(point.cy);
                    x_next   = COORD_WIDTH'(point.cx);
                    y_next   = COORD_WIDTH'(point.cy);
                    n_next   = '0;
                    esc_next = 1'b0;
                    // With a zero limit no test runs at all.
                    state_next = (max_iter_reg == '0) ? ST_DONE : ST_XX;
                end
            end
            ST_XX:
            begin
                state_next = ST_YY;
            end
            ST_YY:
            begin
                xx_next    = prod_reg;
                state_next = ST_XY;
            end
            ST_XY:
            begin
                yy_next    = prod_reg;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (over_thr)
                begin
                    esc_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    n_next = n_inc;
                    x_next = diff_sh[COORD_WIDTH-1:0] + cx_reg;
                    y_next = xy_sh[COORD_WIDTH-1:0] + cy_reg;
                    state_next = (n_inc == max_iter_reg) ? ST_DONE : ST_XX;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = n_reg;
                    out_esc_next   = esc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            max_iter_reg  <= COUNT_WIDTH'(MAX_ITER_RESET);
            radius_reg    <= RADIUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_MAX_ITER: max_iter_reg <= cfg.data[COUNT_WIDTH-1:0];
                    REG_RADIUS:   radius_reg   <= cfg.data[RADIUS_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        n_reg         <= n_next;
        esc_reg       <= esc_next;
        prod_reg      <= prod;
        xx_reg        <= xx_next;
        yy_reg        <= yy_next;
        out_count_reg <= out_count_next;
        out_esc_reg   <= out_esc_next;
    end

endmodule

[hdl/mec_checker.sv]
// Port-level checker for the Mandelbrot escape counter, bound to the top level.
// Depends on mec_pkg and the macros in mandelbrot_escape_count_assert.svh.
`include "mandelbrot_escape_count_assert.svh"

module mec_checker
    import mec_pkg::*;
    #(
        parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
    )
    (
        input logic                   clk,
        input logic                   rst_n,
        input logic                   in_valid,
        input logic                   in_ready,
        input logic                   out_valid,
        input logic                   out_ready,
        input logic [COUNT_WIDTH-1:0] iter_count,
        input logic                   escaped,
        input logic                   cfg_valid,
        input logic                   cfg_ready,
        input cfg_idx_t               cfg_index,
        input cfg_data_t              cfg_data
    );

    // Shadow copy of the iteration limit, tracked from the write channel.
    logic [COUNT_WIDTH-1:0] max_iter_reg, max_iter_next;

    always_comb
    begin
        max_iter_next = max_iter_reg;
        if (cfg_valid && cfg_ready && (cfg_index == REG_MAX_ITER))
        begin
            max_iter_next = cfg_data[COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= COUNT_WIDTH'(MAX_ITER_RESET);
        end
        else
        begin
            max_iter_reg <= max_iter_next;
        end
    end

    // The sequencer is busy on the cycle after it takes a point.
    `MEC_ASSERT_NEXT(a_busy_after_point, in_valid && in_ready, !in_ready, "ready after point")

    // No new result appears on the cycle right after a point is taken while the output register is empty or draining.
    `MEC_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && (!out_valid || out_ready),
        !out_valid, "result too early")

    // A point that never escapes ran the full iteration limit.
    `MEC_ASSERT_NOW(a_limit_count, out_valid && !escaped, iter_count == max_iter_reg,
        "count differs from limit")

    // A stalled result holds its payload.
    `MEC_ASSERT_NEXT(a_result_hold, out_valid && !out_ready,
        out_valid && $stable(iter_count) && $stable(escaped), "stalled result changed")

endmodule

bind mandelbrot_escape_count mec_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_mec_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (point.valid),
    .in_ready   (point.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .iter_count (result.iter_count),
    .escaped    (result.escaped),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data)
);

[verif/mandelbrot_escape_count_tb.sv]
// Self-checking testbench for the Mandelbrot escape-time counter.
// Depends on mec_pkg, the channel interfaces in mec_if.sv and the top level.
`timescale 1ns / 1ps

module mandelbrot_escape_count_tb;
    import mec_pkg::*;

    // Fixed point scale: one unit in Q6.26.
    localparam int ONE  = 1 << FRAC_BITS_DEF;
    localparam int FRAC = FRAC_BITS_DEF;

    // Indexes that the block has no register behind.
    localparam cfg_idx_t REG_UNUSED_LOW = cfg_idx_t'(2);
    localparam cfg_idx_t REG_UNUSED_TOP = cfg_idx_t'(255);

    typedef struct {
        logic [COUNT_WIDTH_DEF-1:0] iter_count;
        logic                       escaped;
    } escape_result_t;

    logic clk;
    logic rst_n;

    mec_point_if                                      point_ch ();
    mec_result_if #(.COUNT_WIDTH(COUNT_WIDTH_DEF))    result_ch ();
    mec_cfg_if                                        cfg_ch ();

    mandelbrot_escape_count #(
        .COORD_WIDTH(COORD_WIDTH_DEF),
        .FRAC_BITS  (FRAC_BITS_DEF),
        .COUNT_WIDTH(COUNT_WIDTH_DEF)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .point (point_ch),
        .result(result_ch),
        .cfg   (cfg_ch)
    );

    // The testbench's own copy of the two registers, updated when a write
    // request is accepted.
    logic [COUNT_WIDTH_DEF-1:0] cur_max_iter;
    logic [RADIUS_W-1:0]        cur_radius;

    // Escape counts still owed by the block, oldest first.
    escape_result_t pending_results[$];

    int  mismatch_count;
    int  error_count;
    bit  idling_on;

    // A receiver hold-off is requested by bumping hold_token; the receiver
    // process notices the change and counts hold_len cycles on its own.
    int  hold_token;
    int  hold_len;
    int  hold_seen;
    int  hold_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Escape-time prediction for one point under the current registers.
    // Coordinates are sign extended to 32 bits, squares are kept at full
    // width for the compare, and the update wraps to 32 bits.
    function automatic escape_result_t predict_escape(
        input logic signed [POINT_W-1:0] cx_in,
        input logic signed [POINT_W-1:0] cy_in
    );
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [63:0] xx;
        logic signed [63:0] yy;
        logic signed [63:0] xy;
        logic signed [63:0] diff;
        logic signed [63:0] shifted;
        logic signed [64:0] mag;
        logic signed [64:0] limit;
        int unsigned        n;
        escape_result_t     r;
        c_re = {cx_in[POINT_W-1], cx_in};
        c_im = {cy_in[POINT_W-1], cy_in};
        x = c_re;
        y = c_im;
        limit = $signed({8'd0, cur_radius, 26'd0});
        n = 0;
        r.escaped = 1'b0;
        while (n < cur_max_iter)
        begin
            xx = x * x;
            yy = y * y;
            mag = xx + yy;
            if (mag > limit)
            begin
                r.escaped = 1'b1;
                break;
            end
            n++;
            diff = xx - yy;
            xy = x * y;
            shifted = diff >>> FRAC;
            x = shifted[31:0] + c_re;
            shifted = xy >>> (FRAC - 1);
            y = shifted[31:0] + c_im;
        end
        r.iter_count = n[COUNT_WIDTH_DEF-1:0];
        return r;
    endfunction

    // Random point: mostly inside the region around the set, where the
    // orbits run long, some anywhere in the legal box, some on all 31 bits.
    function automatic void pick_point(
        output logic signed [POINT_W-1:0] cx_o,
        output logic signed [POINT_W-1:0] cy_o
    );
        int unsigned pick;
        int          re;
        int          im;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            re = -2 * ONE + int'($urandom_range(0, 5 * ONE / 2));
            im = -(5 * ONE / 4) + int'($urandom_range(0, 5 * ONE / 2));
        end
        else if (pick < 90)
        begin
            re = -(8 * ONE) + int'($urandom_range(0, 16 * ONE));
            im = -(8 * ONE) + int'($urandom_range(0, 16 * ONE));
        end
        else
        begin
            re = int'($urandom());
            im = int'($urandom());
        end
        cx_o = re[POINT_W-1:0];
        cy_o = im[POINT_W-1:0];
    endfunction

    // Offer one point request and record its predicted result once it is
    // taken. Called at a falling edge; returns at a falling edge with valid
    // still high, so back-to-back requests drop valid in between only while idling is on.
    task automatic send_point(
        input logic signed [POINT_W-1:0] cx_val,
        input logic signed [POINT_W-1:0] cy_val
    );
        while (idling_on && $urandom_range(99) < 31)
        begin
            point_ch.valid <= 1'b0;
            @(negedge clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.cx    <= cx_val;
        point_ch.cy    <= cy_val;
        do
            @(posedge clk);
        while (point_ch.ready !== 1'b1);
        pending_results.push_back(predict_escape(cx_val, cy_val));
        @(negedge clk);
    endtask

    // One register write request. Only used while the block is idle.
    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            REG_MAX_ITER: cur_max_iter = value[COUNT_WIDTH_DEF-1:0];
            REG_RADIUS:   cur_radius   = value[RADIUS_W-1:0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering points and wait until every owed result has come back.
    task automatic wait_for_results();
        point_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Receiver side: ready changes at the falling edge. A requested hold-off
    // takes precedence over the random idling.
    always @(negedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(99) < 31)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= 1'b1;
    end

    // Result checker: every accepted result request is matched against the
    // oldest prediction, field by field.
    always @(posedge clk)
    begin
        escape_result_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result with nothing owed: count %0d escaped %0b",
                             $realtime, result_ch.iter_count, result_ch.escaped);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.iter_count !== want.iter_count
                    || result_ch.escaped !== want.escaped)
                begin
                    mismatch_count++;
                    error_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch: expected count %0d escaped %0b, got count %0d escaped %0b",
                                 $realtime, want.iter_count, want.escaped,
                                 result_ch.iter_count, result_ch.escaped);
                end
            end
        end
    end

    // Registers at their reset values; includes the boundary point c = 2,
    // whose first test lands exactly on the threshold, and out-of-range
    // coordinates that escape at once.
    task automatic test_reset_defaults();
        send_point('0, '0);
        send_point(POINT_W'(2 * ONE), '0);
        send_point(POINT_W'(-2 * ONE), '0);
        send_point(POINT_W'(8 * ONE), POINT_W'(-8 * ONE));
        send_point(31'sh3FFF_FFFF, 31'sh4000_0000);
        wait_for_results();
    endtask

    // A zero limit runs no test at all; a limit of one and the largest
    // limit are both reached by a point that never escapes.
    task automatic test_iteration_limits();
        write_reg(REG_MAX_ITER, cfg_data_t'(0));
        send_point('0, '0);
        send_point(POINT_W'(8 * ONE), POINT_W'(8 * ONE));
        wait_for_results();
        write_reg(REG_MAX_ITER, cfg_data_t'(1));
        send_point('0, '0);
        send_point(POINT_W'(-ONE), POINT_W'(ONE / 4));
        wait_for_results();
        write_reg(REG_MAX_ITER, cfg_data_t'(65535));
        send_point('0, '0);
        wait_for_results();
    endtask

    // Threshold at zero, at its largest legal value, and at all ones with
    // bit 31 of the write data set, which the register must drop.
    task automatic test_threshold_extremes();
        write_reg(REG_MAX_ITER, cfg_data_t'(16));
        write_reg(REG_RADIUS, cfg_data_t'(0));
        send_point('0, '0);
        send_point(POINT_W'(1), '0);
        wait_for_results();
        write_reg(REG_RADIUS, cfg_data_t'(32'h4000_0000));
        send_point(POINT_W'(3 * ONE), '0);
        wait_for_results();
        write_reg(REG_RADIUS, 32'hFFFF_FFFF);
        send_point(31'sh3FFF_FFFF, '0);
        send_point(POINT_W'(5 * ONE), '0);
        wait_for_results();
    endtask

    // Writes to indexes with no register behind them must change nothing.
    task automatic test_unknown_register();
        write_reg(REG_MAX_ITER, cfg_data_t'(MAX_ITER_RESET));
        write_reg(REG_RADIUS, cfg_data_t'(RADIUS_RESET));
        write_reg(REG_UNUSED_LOW, cfg_data_t'($urandom()));
        write_reg(REG_UNUSED_TOP, cfg_data_t'($urandom()));
        send_point('0, '0);
        send_point(POINT_W'(2 * ONE), '0);
        wait_for_results();
    endtask

    // The receiver holds ready low for a long stretch while points keep
    // coming, so the output register and then the sequencer fill up and
    // the point channel stalls.
    task automatic test_result_backpressure();
        logic signed [POINT_W-1:0] cx_val;
        logic signed [POINT_W-1:0] cy_val;
        write_reg(REG_MAX_ITER, cfg_data_t'(8));
        hold_len = 300;
        hold_token++;
        repeat (12)
        begin
            pick_point(cx_val, cy_val);
            send_point(cx_val, cy_val);
        end
        wait_for_results();
    endtask

    // Random points over several register settings. Each phase starts from
    // an idle block; now and then the sender also pauses mid-phase until all
    // owed results are back. One phase runs without any idling.
    task automatic test_random_points();
        int unsigned               ph_iter[9];
        int unsigned               ph_radius[9];
        int                        ph_count[9];
        bit                        ph_steady[9];
        logic signed [POINT_W-1:0] cx_val;
        logic signed [POINT_W-1:0] cy_val;
        ph_iter   = '{0, 1, 8, 32, 32, 64, 256, 1000, 0};
        ph_radius = '{268435456, 0, 268435456, 0, 1073741824, 0, 268435456,
                      268435456, 0};
        ph_count  = '{60, 150, 250, 150, 200, 250, 150, 40, 200};
        ph_steady = '{0, 0, 1, 0, 0, 0, 0, 0, 0};
        ph_radius[1] = $urandom_range(0, 1073741824);
        ph_radius[5] = $urandom_range(0, 1073741824);
        ph_iter[8]   = $urandom_range(1, 100);
        ph_radius[8] = $urandom_range(0, 1073741824);
        for (int p = 0; p < 9; p++)
        begin
            wait_for_results();
            write_reg(REG_MAX_ITER, cfg_data_t'(ph_iter[p]));
            write_reg(REG_RADIUS, cfg_data_t'(ph_radius[p]));
            idling_on = !ph_steady[p];
            for (int i = 0; i < ph_count[p]; i++)
            begin
                if ($urandom_range(199) == 0)
                    wait_for_results();
                pick_point(cx_val, cy_val);
                send_point(cx_val, cy_val);
            end
        end
        wait_for_results();
        idling_on = 1'b1;
    endtask

    initial
    begin
        cur_max_iter    = COUNT_WIDTH_DEF'(MAX_ITER_RESET);
        cur_radius      = RADIUS_RESET;
        mismatch_count  = 0;
        error_count     = 0;
        idling_on       = 1'b1;
        hold_token      = 0;
        hold_len        = 0;
        hold_seen       = 0;
        hold_left       = 0;
        rst_n           = 1'b0;
        point_ch.valid  = 1'b0;
        point_ch.cx     = '0;
        point_ch.cy     = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_iteration_limits();
        test_threshold_extremes();
        test_unknown_register();
        test_result_backpressure();
        test_random_points();

        // Let any stray result request show up before the verdict.
        repeat (40) @(negedge clk);
        if (error_count == 0)
            $display("[mandelbrot_escape_count] OK");
        else
            $display("[mandelbrot_escape_count] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, including the single
    // point that runs the largest iteration limit.
    initial
    begin
        #(64'd50_000_000);
        $display("[mandelbrot_escape_count] ERROR");
        $finish;
    end

endmodule
